/* src/polyphase_fractional_delay_line_macros.svh */
// Assertion macros shared by the delay line RTL.
`ifndef POLYPHASE_FRACTIONAL_DELAY_LINE_MACROS_SVH
`define POLYPHASE_FRACTIONAL_DELAY_LINE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PFDL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PFDL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define PFDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pfdl_pkg.sv */
// Constants, types and widths of the polyphase fractional delay line.
package pfdl_pkg;

  // Sizing of the line and the interpolator (PHASE_COUNT is a power of two)
  localparam int LINE_DEPTH  = 4096;
  localparam int TAP_COUNT   = 16;
  localparam int PHASE_COUNT = 64;
  localparam int COEF_DEPTH  = PHASE_COUNT * TAP_COUNT;

  // Fixed field widths
  localparam int ACT_W    = 2;
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 18;
  localparam int CIDX_W   = 10;
  localparam int COEF_W   = 18;
  localparam int CFG_W    = 13;
  localparam int FRAC_SHIFT = 16;

  // Derived widths
  localparam int ADDR_W   = $clog2(LINE_DEPTH);
  localparam int LEN_W    = ADDR_W + 1;
  localparam int PHASE_W  = $clog2(PHASE_COUNT);
  localparam int WHOLE_W  = DELAY_W - PHASE_W;
  localparam int TAP_W    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int COEF_AW  = $clog2(COEF_DEPTH);
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT);
  localparam int Q_W      = ACC_W - FRAC_SHIFT;

  // Rounding and saturation constants
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

  // Actions carried by an input beat
  typedef enum logic [ACT_W-1:0] {
    ACT_FEED    = 2'd0,
    ACT_READ    = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_LOAD    = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAPS,
    ST_FINISH
  } state_t;

endpackage

/* src/polyphase_fractional_delay_line.sv */
// Delay line with sample and coefficient memories and a one-tap-per-cycle MAC read.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | action, sample_in, delay_subsamples,
//          |           |                    | coef_index, coef_value
//  out_    | output    | out_valid/out_stall| read_value
//  cfg_    | input     | cfg_valid/cfg_ready| line_length
//
// Feed, advance and load complete while idle; a read walks the taps one per cycle through the
// single read port of the sample memory, then multiply and accumulate registers, and is rounded
// into the result register; in_stall stays high until the read is finished.
// After reset all LINE_DEPTH (4096) slots of the sample memory are zeroed, with in_stall high.
// The result register holds a read until taken; a stalled output holds the read's last stage.
module polyphase_fractional_delay_line (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfdl_pkg::ACT_W-1:0]    in_action,
  input  logic [pfdl_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [pfdl_pkg::DELAY_W-1:0]  in_delay_subsamples,
  input  logic [pfdl_pkg::CIDX_W-1:0]   in_coef_index,
  input  logic [pfdl_pkg::COEF_W-1:0]   in_coef_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfdl_pkg::SAMPLE_W-1:0] out_read_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfdl_pkg::CFG_W-1:0]    cfg_line_length
);
  import pfdl_pkg::*;

  // Memories
  logic [SAMPLE_W-1:0] smem [LINE_DEPTH];
  logic [COEF_W-1:0]   cmem [COEF_DEPTH];

  // Control state
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [ADDR_W-1:0]   wp_r;
  logic [LEN_W-1:0]    len_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [TAP_W-1:0]    tap_r;
  logic [COEF_AW-1:0]  cbase_r;

  // MAC pipeline
  logic                       s1_vld_r, s1_last_r;
  logic                       s2_vld_r, s2_last_r;
  logic                       acc_done_r;
  logic signed [SAMPLE_W-1:0] samp_q_r;
  logic signed [COEF_W-1:0]   coef_q_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;

  // Result register
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_read_value_r;

  // Combinational helpers
  action_t                    act;
  logic                       in_acc, cfg_acc, out_free, issue, issue_last, fin_fire;
  logic                       clr_last;
  logic [LEN_W-1:0]           lenm1;
  logic [ADDR_W-1:0]          addr_nxt;
  logic [COEF_AW-1:0]         caddr;
  logic [WHOLE_W-1:0]         whole;
  logic [31:0]                whole32, lenm1_32;
  logic [ADDR_W-1:0]          whole_c;
  logic [LEN_W:0]             diff, start_w;
  logic [LEN_W-1:0]           len_new;
  logic [31:0]                cfg32;
  logic                       smem_we;
  logic [ADDR_W-1:0]          smem_wa;
  logic [SAMPLE_W-1:0]        smem_wd;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [Q_W-1:0]      q;
  logic [SAMPLE_W-1:0]        sat;

  assign act        = action_t'(in_action);
  assign in_acc     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_read_value = out_read_value_r;

  // Step back one slot, wrapping at the line length
  assign lenm1    = len_r - LEN_W'(1);
  assign addr_nxt = (addr_r == '0) ? lenm1[ADDR_W-1:0] : addr_r - ADDR_W'(1);
  assign caddr    = cbase_r + COEF_AW'(tap_r);

  // Split the delay and find the slot just past the newest tap
  assign whole    = in_delay_subsamples[DELAY_W-1:PHASE_W];
  assign whole32  = 32'(whole);
  assign lenm1_32 = 32'(lenm1);
  assign whole_c  = (whole32 > lenm1_32) ? lenm1_32[ADDR_W-1:0] : whole32[ADDR_W-1:0];
  assign diff     = (LEN_W+1)'(wp_r) - (LEN_W+1)'(whole_c);
  assign start_w  = diff[LEN_W] ? diff + (LEN_W+1)'(len_r) : diff;

  // Effective length of a configuration write
  assign cfg32 = 32'(cfg_line_length);
  always_comb begin
    if (cfg32 == 32'd0) begin
      len_new = LEN_W'(1);
    end else if (cfg32 > 32'(LINE_DEPTH)) begin
      len_new = LEN_W'(LINE_DEPTH);
    end else begin
      len_new = cfg32[LEN_W-1:0];
    end
  end

  // Round half up, drop the fraction, saturate
  assign rnd     = acc_r + ROUND_BIAS;
  assign shifted = rnd >>> FRAC_SHIFT;
  assign q       = shifted[Q_W-1:0];
  always_comb begin
    if (q > Q_MAX) begin
      sat = Q_MAX[SAMPLE_W-1:0];
    end else if (q < Q_MIN) begin
      sat = Q_MIN[SAMPLE_W-1:0];
    end else begin
      sat = q[SAMPLE_W-1:0];
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    issue      = 1'b0;
    issue_last = 1'b0;
    fin_fire   = 1'b0;
    clr_last   = (clr_cnt_r == ADDR_W'(LINE_DEPTH - 1));
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && act == ACT_READ) state_nxt = ST_TAPS;
      end
      ST_TAPS: begin
        issue      = 1'b1;
        issue_last = (tap_r == '0);
        if (issue_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (acc_done_r && out_free) begin
          fin_fire  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Sample memory write port: zero sweep, else feed at the write pointer
  always_comb begin
    smem_we = 1'b0;
    smem_wa = wp_r;
    smem_wd = in_sample_in;
    if (state_r == ST_CLEAR) begin
      smem_we = 1'b1;
      smem_wa = clr_cnt_r;
      smem_wd = '0;
    end else if (in_acc && act == ACT_FEED) begin
      smem_we = 1'b1;
    end
  end

  // Sample memory
  always_ff @(posedge clk) begin
    if (smem_we) smem[smem_wa] <= smem_wd;
    samp_q_r <= smem[addr_nxt];
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (in_acc && act == ACT_LOAD && 32'(in_coef_index) < 32'(COEF_DEPTH)) begin
      cmem[COEF_AW'(in_coef_index)] <= in_coef_value;
    end
    coef_q_r <= cmem[caddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // Pointer, length and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      wp_r      <= '0;
      len_r     <= LEN_W'(LINE_DEPTH);
    end else begin
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (cfg_acc) begin
        len_r <= len_new;
        if (LEN_W'(wp_r) >= len_new) wp_r <= '0;
      end else if (in_acc && act == ACT_ADVANCE) begin
        if (LEN_W'(wp_r) + LEN_W'(1) >= len_r) wp_r <= '0;
        else                                   wp_r <= wp_r + ADDR_W'(1);
      end
    end
  end

  // Read set-up and tap walk (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_acc && act == ACT_READ) begin
      addr_r  <= start_w[ADDR_W-1:0];
      tap_r   <= TAP_W'(TAP_COUNT - 1);
      cbase_r <= COEF_AW'(in_delay_subsamples[PHASE_W-1:0]) * COEF_AW'(TAP_COUNT);
    end else if (issue) begin
      addr_r <= addr_nxt;
      tap_r  <= tap_r - TAP_W'(1);
    end
  end

  // MAC pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_vld_r   <= 1'b0;
      s2_last_r  <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      s1_vld_r  <= issue;
      s1_last_r <= issue_last;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      if (fin_fire)                   acc_done_r <= 1'b0;
      else if (s2_vld_r && s2_last_r) acc_done_r <= 1'b1;
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    prod_r <= samp_q_r * coef_q_r;
    if (in_acc && act == ACT_READ) acc_r <= '0;
    else if (s2_vld_r)             acc_r <= acc_r + ACC_W'(prod_r);
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) out_read_value_r <= sat;
  end

  `include "polyphase_fractional_delay_line_macros.svh"

  `PFDL_ASSERT_ALWAYS(a_wp_in_line, LEN_W'(wp_r) < len_r, "write pointer beyond line length")
  `PFDL_ASSERT_SAME(a_done_in_finish, acc_done_r, state_r == ST_FINISH, "sum ready outside finish")
  `PFDL_ASSERT_SAME(a_mac_busy, s1_vld_r || s2_vld_r, state_r == ST_TAPS || state_r == ST_FINISH, "stray tap in pipeline")
  `PFDL_ASSERT_NEXT(a_result_held, out_valid_r && out_stall, out_valid_r && $stable(out_read_value_r), "stalled result lost")

endmodule
